/* src/mzc_pkg.sv */
`timescale 1ns / 1ps

package mzc_pkg;

  // Command codes carried in the input tuser field.
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // Event codes carried in the output tuser field.
  typedef enum logic [2:0] {
    EV_IDLE      = 3'd0,
    EV_CARVED    = 3'd1,
    EV_BACKTRACK = 3'd2,
    EV_FINISHED  = 3'd3,
    EV_WALLS     = 3'd4
  } event_t;

  // Direction codes, also the bit position of the matching wall.
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_W = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_E = 2'd3;

  // XOR with this turns a direction into its opposite.
  localparam logic [1:0] DIR_FLIP = 2'd2;

  localparam logic [3:0] ALL_WALLS = 4'hF;

  // Controller states.
  typedef enum logic [3:0] {
    S_CLEAR_RST,
    S_CLEAR_CMD,
    S_IDLE,
    S_READ,
    S_READ_DATA,
    S_HERE,
    S_MARK,
    S_NB,
    S_DECIDE,
    S_POP,
    S_CARVE,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   accept;
    logic   clear_start;
    logic   clear_step;
    logic   rd_cell;
    logic   walls_load;
    logic   mark;
    logic   nb_step;
    logic   pop_issue;
    logic   pop_load;
    logic   carve_issue;
    logic   carve_load;
    logic   set_finished;
    logic   res_load;
    event_t res_ev;
    logic   out_load;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic finished;
    logic any_open;
    logic dir_open;
    logic count_full;
    logic depth_zero;
    logic nb_last;
    logic clear_last;
    logic out_free;
  } sts_t;

  // One-hot wall bit for a direction.
  function automatic logic [3:0] dir_mask(input logic [1:0] d);
    dir_mask = 4'b0001 << d;
  endfunction

endpackage

/* src/mzc_ctrl.sv */
`timescale 1ns / 1ps

module mzc_ctrl import mzc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  output logic       in_ready,
  input  sts_t       sts,
  output ctl_t       ctl
);

  state_t state;
  state_t state_next;

  // State register; reset starts the clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR_RST;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR_RST: begin
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_CLEAR_CMD: begin
        if (sts.clear_last) state_next = S_EMIT;
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (cmd_t'(in_command))
            CMD_START: state_next = S_CLEAR_CMD;
            CMD_STEP:  state_next = sts.finished ? S_EMIT : S_HERE;
            CMD_READ:  state_next = S_READ;
            default:   state_next = S_EMIT;
          endcase
        end
      end
      S_READ:      state_next = S_READ_DATA;
      S_READ_DATA: state_next = S_EMIT;
      S_HERE:      state_next = S_MARK;
      S_MARK:      state_next = S_NB;
      S_NB: begin
        if (sts.nb_last) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (!sts.any_open && !sts.count_full && !sts.depth_zero) begin
          state_next = S_POP;
        end else if (sts.any_open && sts.dir_open) begin
          state_next = S_CARVE;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_POP:   state_next = S_EMIT;
      S_CARVE: state_next = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath commands for each state.
  always_comb begin
    ctl        = '0;
    ctl.res_ev = EV_IDLE;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR_RST, S_CLEAR_CMD: begin
        ctl.clear_step = 1'b1;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.accept = 1'b1;
          unique case (cmd_t'(in_command))
            CMD_START: begin
              ctl.clear_start = 1'b1;
              ctl.res_load    = 1'b1;
              ctl.res_ev      = EV_IDLE;
            end
            CMD_STEP: begin
              if (sts.finished) begin
                ctl.res_load = 1'b1;
                ctl.res_ev   = EV_FINISHED;
              end
            end
            CMD_READ: begin
            end
            default: begin
              ctl.res_load = 1'b1;
              ctl.res_ev   = EV_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        ctl.rd_cell = 1'b1;
      end
      S_READ_DATA: begin
        ctl.walls_load = 1'b1;
        ctl.res_load   = 1'b1;
        ctl.res_ev     = EV_WALLS;
      end
      S_HERE: begin
      end
      S_MARK: begin
        ctl.mark = 1'b1;
      end
      S_NB: begin
        ctl.nb_step = 1'b1;
      end
      S_DECIDE: begin
        priority if (!sts.any_open && sts.count_full) begin
          ctl.set_finished = 1'b1;
          ctl.res_load     = 1'b1;
          ctl.res_ev       = EV_FINISHED;
        end else if (!sts.any_open && sts.depth_zero) begin
          ctl.res_load = 1'b1;
          ctl.res_ev   = EV_IDLE;
        end else if (!sts.any_open) begin
          ctl.pop_issue = 1'b1;
        end else if (sts.dir_open) begin
          ctl.carve_issue = 1'b1;
        end else begin
          ctl.res_load = 1'b1;
          ctl.res_ev   = EV_IDLE;
        end
      end
      S_POP: begin
        ctl.pop_load = 1'b1;
        ctl.res_load = 1'b1;
        ctl.res_ev   = EV_BACKTRACK;
      end
      S_CARVE: begin
        ctl.carve_load = 1'b1;
        ctl.res_load   = 1'b1;
        ctl.res_ev     = EV_CARVED;
      end
      S_EMIT: begin
        ctl.out_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/mzc_datapath.sv */
`timescale 1ns / 1ps

module mzc_datapath import mzc_pkg::*; #(
  parameter int GRID_SIDE = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  ctl_t       ctl,
  output sts_t       sts,
  input  logic [1:0] in_command,
  input  logic [1:0] in_direction,
  input  logic [2:0] in_read_x,
  input  logic [2:0] in_read_y,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_event,
  output logic [2:0] out_x,
  output logic [2:0] out_y,
  output logic [1:0] out_opened,
  output logic [3:0] out_walls
);

  localparam int CW    = $clog2(GRID_SIDE);
  localparam int AW    = 2 * CW;
  localparam int MEM_D = 1 << AW;
  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int SAW   = $clog2(CELLS);
  localparam int DW    = $clog2(CELLS + 1);
  localparam int XW    = (CW > 3) ? CW + 1 : 4;
  localparam int VIS   = 4;

  localparam logic [CW-1:0] EDGE = CW'(GRID_SIDE - 1);

  // Latched transfer.
  cmd_t          cmd_l;
  logic [1:0]    dir_l;
  logic [2:0]    rx_l;
  logic [2:0]    ry_l;

  // Walker and walk bookkeeping.
  logic [CW-1:0] wx;
  logic [CW-1:0] wy;
  logic [DW-1:0] depth;
  logic [DW-1:0] count;
  logic          finished;
  logic [AW-1:0] clr_addr;
  logic [1:0]    nb_k;
  logic [3:0]    open_mask;
  logic [3:0]    here_walls;
  event_t        res_ev;
  logic [3:0]    res_walls;

  // Cell memory: visited flag over four wall bits, addressed by {y, x}.
  logic [4:0]    cell_mem [MEM_D];
  logic [4:0]    rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [4:0]    wdata;
  logic          we;

  // Backtrack stack of {y, x} positions.
  logic [AW-1:0] stk_mem [CELLS];
  logic [AW-1:0] stk_rdata;

  logic [CW-1:0] nb_x [4];
  logic [CW-1:0] nb_y [4];
  logic [3:0]    nb_in;
  logic [AW-1:0] here;
  logic [AW-1:0] there;
  logic [1:0]    nb_k_inc;
  logic          rd_in_grid;
  logic          out_free;
  logic [DW-1:0] depth_dec;
  logic          can_push;

  assign here      = {wy, wx};
  assign there     = {nb_y[dir_l], nb_x[dir_l]};
  assign nb_k_inc  = nb_k + 2'd1;
  assign depth_dec = depth - DW'(1);
  assign can_push  = depth < DW'(CELLS);
  assign out_free  = !out_valid || out_ready;
  assign rd_in_grid = (XW'(rx_l) < XW'(GRID_SIDE)) && (XW'(ry_l) < XW'(GRID_SIDE));

  // Neighbours of the walker and whether each lies on the grid.
  always_comb begin
    nb_x[DIR_N] = wx;
    nb_y[DIR_N] = wy - CW'(1);
    nb_in[DIR_N] = (wy != '0);
    nb_x[DIR_W] = wx - CW'(1);
    nb_y[DIR_W] = wy;
    nb_in[DIR_W] = (wx != '0);
    nb_x[DIR_S] = wx;
    nb_y[DIR_S] = wy + CW'(1);
    nb_in[DIR_S] = (wy != EDGE);
    nb_x[DIR_E] = wx + CW'(1);
    nb_y[DIR_E] = wy;
    nb_in[DIR_E] = (wx != EDGE);
  end

  // Input transfer capture.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_l <= cmd_t'(in_command);
      dir_l <= in_direction;
      rx_l  <= in_read_x;
      ry_l  <= in_read_y;
    end
  end

  // Walker, stack depth, marked-cell count and finished flag.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear_start) begin
      wx       <= '0;
      wy       <= '0;
      depth    <= '0;
      count    <= '0;
      finished <= 1'b0;
    end else begin
      if (ctl.pop_load) begin
        {wy, wx} <= stk_rdata;
      end else if (ctl.carve_load) begin
        wx <= nb_x[dir_l];
        wy <= nb_y[dir_l];
      end
      if (ctl.mark && !rdata[VIS]) count <= count + DW'(1);
      if (ctl.carve_issue && can_push) begin
        depth <= depth + DW'(1);
      end else if (ctl.pop_issue) begin
        depth <= depth_dec;
      end
      if (ctl.set_finished) finished <= 1'b1;
    end
  end

  // Clearing sweep address.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear_start) begin
      clr_addr <= '0;
    end else if (ctl.clear_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Neighbour scan: one neighbour's visited bit arrives each cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      nb_k <= '0;
    end else if (ctl.mark) begin
      nb_k <= '0;
    end else if (ctl.nb_step) begin
      nb_k <= nb_k_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.nb_step) open_mask[nb_k] <= nb_in[nb_k] && !rdata[VIS];
    if (ctl.mark) here_walls <= rdata[3:0];
  end

  // Cell memory read address.
  always_comb begin
    priority if (ctl.mark) begin
      raddr = {nb_y[DIR_N], nb_x[DIR_N]};
    end else if (ctl.nb_step) begin
      raddr = {nb_y[nb_k_inc], nb_x[nb_k_inc]};
    end else if (ctl.rd_cell) begin
      raddr = {CW'(ry_l), CW'(rx_l)};
    end else if (ctl.carve_issue) begin
      raddr = there;
    end else begin
      raddr = here;
    end
  end

  // Cell memory write port.
  always_comb begin
    we = ctl.clear_step || ctl.mark || ctl.carve_issue || ctl.carve_load;
    priority if (ctl.clear_step) begin
      waddr = clr_addr;
      wdata = {1'b0, ALL_WALLS};
    end else if (ctl.mark) begin
      waddr = here;
      wdata = {1'b1, rdata[3:0]};
    end else if (ctl.carve_issue) begin
      waddr = here;
      wdata = {1'b1, here_walls & ~dir_mask(dir_l)};
    end else begin
      waddr = there;
      wdata = {rdata[VIS], rdata[3:0] & ~dir_mask(dir_l ^ DIR_FLIP)};
    end
  end

  always_ff @(posedge clk) begin
    if (we) cell_mem[waddr] <= wdata;
    rdata <= cell_mem[raddr];
  end

  // Stack push on a carve, registered read on a pop.
  always_ff @(posedge clk) begin
    if (ctl.carve_issue && can_push) stk_mem[depth[SAW-1:0]] <= here;
    if (ctl.pop_issue) stk_rdata <= stk_mem[depth_dec[SAW-1:0]];
  end

  // Pending result.
  always_ff @(posedge clk) begin
    if (ctl.res_load) res_ev <= ctl.res_ev;
    if (ctl.walls_load) res_walls <= rd_in_grid ? rdata[3:0] : ALL_WALLS;
  end

  // Output register; it holds a result until the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_event  <= res_ev;
      out_x      <= (cmd_l == CMD_READ) ? rx_l : 3'(wx);
      out_y      <= (cmd_l == CMD_READ) ? ry_l : 3'(wy);
      out_opened <= (res_ev == EV_CARVED) ? dir_l : 2'd0;
      out_walls  <= (res_ev == EV_WALLS) ? res_walls : 4'd0;
    end
  end

  // Status for the controller.
  always_comb begin
    sts.finished   = finished;
    sts.any_open   = |open_mask;
    sts.dir_open   = open_mask[dir_l];
    sts.count_full = count >= DW'(CELLS);
    sts.depth_zero = (depth == '0);
    sts.nb_last    = (nb_k == 2'd3);
    sts.clear_last = &clr_addr;
    sts.out_free   = out_free;
  end

endmodule

/* src/dfs_maze_carver_top.sv */
`timescale 1ns / 1ps
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: command; tdata: direction, read_x, read_y
// m_axis    out  m_axis_tvalid / m_axis_tready  tuser: event_res; tdata: cell_x, cell_y,
//                                               opened_dir, walls
//
// One transfer is taken at a time. A carve step is paced by the single read port of the cell
// memory: the walker's cell and its four neighbours are read one per cycle. A read passes
// through S_READ and S_READ_DATA; an unknown command or a step after the finish goes straight
// to S_EMIT. A start command, and reset, sweep the cell memory one entry a cycle, through all
// 2**(2*clog2(GRID_SIDE)) entries (64 at the default side), with s_axis_tready low.
// A result waits in the output register while m_axis_tready is low; the next transfer is
// taken meanwhile and its work stops only when its own result is due.

module dfs_maze_carver_top import mzc_pkg::*; #(
  parameter int GRID_SIDE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] direction, [4:2] read_x, [7:5] read_y
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] cell_x, [5:3] cell_y, [7:6] opened_dir,
                                      // [11:8] walls, [15:12] zero
  output logic [2:0]  m_axis_tuser    // [2:0] event_res
);

  ctl_t       ctl;
  sts_t       sts;
  logic [2:0] out_x;
  logic [2:0] out_y;
  logic [1:0] out_opened;
  logic [3:0] out_walls;

  mzc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_command (s_axis_tuser),
    .in_ready   (s_axis_tready),
    .sts        (sts),
    .ctl        (ctl)
  );

  mzc_datapath #(
    .GRID_SIDE (GRID_SIDE)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .in_command   (s_axis_tuser),
    .in_direction (s_axis_tdata[1:0]),
    .in_read_x    (s_axis_tdata[4:2]),
    .in_read_y    (s_axis_tdata[7:5]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_event    (m_axis_tuser),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_opened   (out_opened),
    .out_walls    (out_walls)
  );

  assign m_axis_tdata = {4'd0, out_walls, out_opened, out_y, out_x};

  // A start transfer is followed by the clearing sweep, so no transfer is taken next cycle.
  a_start_blocks : assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_START) |=> !s_axis_tready)
    else $error("transfer accepted straight after a start command");

  // Only a carve result names an opened wall, only a wall read carries wall bits.
  a_fields_clean : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tuser == EV_CARVED) || (m_axis_tdata[7:6] == 2'd0)) &&
                      ((m_axis_tuser == EV_WALLS) || (m_axis_tdata[11:8] == 4'd0)))
    else $error("opened_dir or walls set for the wrong event");

  // A read outside the grid reports every wall up.
  a_outside_walls : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == EV_WALLS) &&
    ((int'(m_axis_tdata[2:0]) >= GRID_SIDE) || (int'(m_axis_tdata[5:3]) >= GRID_SIDE))
    |-> (m_axis_tdata[11:8] == ALL_WALLS))
    else $error("read outside the grid did not return all walls");

  // The output register is loaded only when it is free.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before its transfer");

endmodule

/* dv/dfs_maze_carver_top_tb.sv */
`timescale 1ns / 1ps

module dfs_maze_carver_top_tb;
  import mzc_pkg::*;

  localparam int CELL_COUNT   = 64;
  localparam int RANDOM_ITEMS = 1900;
  localparam int NUM_DIRECTED = 22;
  localparam int TOTAL_ITEMS  = NUM_DIRECTED + RANDOM_ITEMS;

  // Command code that the block does not know.
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    event_t     ev;
    logic [2:0] x;
    logic [2:0] y;
    logic [1:0] od;
    logic [3:0] walls;
  } maze_result_t;

  typedef struct packed {
    logic [1:0]   cmd;
    logic [1:0]   dir;
    logic [2:0]   rx;
    logic [2:0]   ry;
    logic         typed;
    maze_result_t want;
  } directed_row_t;

  localparam maze_result_t NO_RESULT = '{EV_IDLE, 3'd0, 3'd0, 2'd0, 4'd0};

  // Directed rows. A typed row carries its own expected result; the others are predicted.
  localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
    '{CMD_READ,    DIR_N, 3'd0, 3'd0, 1'b1, '{EV_WALLS, 3'd0, 3'd0, 2'd0, ALL_WALLS}},
    '{CMD_READ,    DIR_E, 3'd7, 3'd7, 1'b1, '{EV_WALLS, 3'd7, 3'd7, 2'd0, ALL_WALLS}},
    '{CMD_UNKNOWN, DIR_E, 3'd7, 3'd7, 1'b1, '{EV_IDLE, 3'd0, 3'd0, 2'd0, 4'd0}},
    '{CMD_STEP,    DIR_N, 3'd0, 3'd0, 1'b1, '{EV_IDLE, 3'd0, 3'd0, 2'd0, 4'd0}},
    '{CMD_STEP,    DIR_W, 3'd7, 3'd0, 1'b1, '{EV_IDLE, 3'd0, 3'd0, 2'd0, 4'd0}},
    '{CMD_STEP,    DIR_S, 3'd0, 3'd7, 1'b1, '{EV_CARVED, 3'd0, 3'd1, DIR_S, 4'd0}},
    '{CMD_STEP,    DIR_N, 3'd0, 3'd0, 1'b0, NO_RESULT},
    '{CMD_STEP,    DIR_E, 3'd0, 3'd0, 1'b0, NO_RESULT},
    '{CMD_STEP,    DIR_N, 3'd0, 3'd0, 1'b0, NO_RESULT},
    '{CMD_STEP,    DIR_W, 3'd0, 3'd0, 1'b0, NO_RESULT},
    '{CMD_READ,    DIR_N, 3'd0, 3'd0, 1'b0, NO_RESULT},
    '{CMD_READ,    DIR_N, 3'd0, 3'd1, 1'b0, NO_RESULT},
    '{CMD_START,   DIR_S, 3'd5, 3'd2, 1'b1, '{EV_IDLE, 3'd0, 3'd0, 2'd0, 4'd0}},
    '{CMD_STEP,    DIR_E, 3'd0, 3'd0, 1'b0, NO_RESULT},
    '{CMD_STEP,    DIR_S, 3'd0, 3'd0, 1'b0, NO_RESULT},
    '{CMD_STEP,    DIR_S, 3'd0, 3'd0, 1'b0, NO_RESULT},
    '{CMD_STEP,    DIR_W, 3'd0, 3'd0, 1'b0, NO_RESULT},
    '{CMD_STEP,    DIR_N, 3'd0, 3'd0, 1'b0, NO_RESULT},
    '{CMD_STEP,    DIR_E, 3'd0, 3'd0, 1'b0, NO_RESULT},
    '{CMD_STEP,    DIR_S, 3'd0, 3'd0, 1'b0, NO_RESULT},
    '{CMD_READ,    DIR_N, 3'd5, 3'd2, 1'b0, NO_RESULT},
    '{CMD_READ,    DIR_N, 3'd2, 3'd5, 1'b0, NO_RESULT}
  };

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic [1:0]  s_axis_tuser  = 2'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  // Maze state as the predictor sees it.
  logic       visited_cells [CELL_COUNT];
  logic [3:0] wall_bits [CELL_COUNT];
  logic [5:0] trail [CELL_COUNT];
  int         trail_depth;
  logic [2:0] walker_col;
  logic [2:0] walker_row;
  int         marked_cells;
  logic       maze_done;

  maze_result_t pending_results[$];
  int errors;
  int items_sent;
  int mazes_completed;
  int event_tally [5];
  int snd_idle_pct;
  int rcv_idle_pct;

  dfs_maze_carver_top #(.GRID_SIDE(8)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Clears the visited map, raises every wall and puts the walker at the origin.
  function automatic void clear_maze();
    for (int c = 0; c < CELL_COUNT; c++) begin
      visited_cells[c] = 1'b0;
      wall_bits[c]     = ALL_WALLS;
      trail[c]         = 6'd0;
    end
    trail_depth  = 0;
    walker_col   = 3'd0;
    walker_row   = 3'd0;
    marked_cells = 0;
    maze_done    = 1'b0;
  endfunction

  // Neighbour of a cell in one direction; zero when it would leave the grid.
  function automatic logic step_target(input logic [2:0] x, input logic [2:0] y,
                                       input logic [1:0] d,
                                       output logic [2:0] nx, output logic [2:0] ny);
    logic inside_grid;
    nx = x;
    ny = y;
    inside_grid = 1'b1;
    case (d)
      DIR_N: if (y == 3'd0) inside_grid = 1'b0; else ny = y - 3'd1;
      DIR_W: if (x == 3'd0) inside_grid = 1'b0; else nx = x - 3'd1;
      DIR_S: if (y == 3'd7) inside_grid = 1'b0; else ny = y + 3'd1;
      default: if (x == 3'd7) inside_grid = 1'b0; else nx = x + 3'd1;
    endcase
    return inside_grid;
  endfunction

  // One bit per direction whose neighbour is on the grid and not yet visited.
  function automatic logic [3:0] open_mask();
    logic [3:0] ways;
    logic [2:0] nx, ny;
    ways = 4'd0;
    for (int d = 0; d < 4; d++) begin
      if (step_target(walker_col, walker_row, d[1:0], nx, ny) && !visited_cells[{ny, nx}])
        ways[d] = 1'b1;
    end
    return ways;
  endfunction

  // Applies one accepted command to the maze state and returns the result it gives.
  function automatic maze_result_t predict_item(input logic [1:0] cmd, input logic [1:0] dir,
                                                input logic [2:0] rx, input logic [2:0] ry);
    maze_result_t r;
    logic [5:0] here, there;
    logic [2:0] nx, ny;
    logic [3:0] ways;
    logic       moved;
    r = NO_RESULT;
    case (cmd)
      CMD_START: clear_maze();
      CMD_STEP: begin
        if (maze_done) begin
          r.ev = EV_FINISHED;
        end else begin
          here = {walker_row, walker_col};
          if (!visited_cells[here]) begin
            visited_cells[here] = 1'b1;
            marked_cells++;
          end
          ways = open_mask();
          if (ways == 4'd0) begin
            // Walled in: finish, stay put with an empty path, or retreat one cell.
            if (marked_cells >= CELL_COUNT) begin
              maze_done = 1'b1;
              mazes_completed++;
              r.ev = EV_FINISHED;
            end else if (trail_depth != 0) begin
              trail_depth--;
              here       = trail[trail_depth];
              walker_col = here[2:0];
              walker_row = here[5:3];
              r.ev       = EV_BACKTRACK;
            end
          end else if (ways[dir]) begin
            moved = step_target(walker_col, walker_row, dir, nx, ny);
            there = {ny, nx};
            wall_bits[here]  = wall_bits[here] & ~(4'b0001 << dir);
            wall_bits[there] = wall_bits[there] & ~(4'b0001 << (dir ^ DIR_FLIP));
            if (trail_depth < CELL_COUNT) begin
              trail[trail_depth] = here;
              trail_depth++;
            end
            walker_col = nx;
            walker_row = ny;
            r.od       = dir;
            r.ev       = moved ? EV_CARVED : EV_IDLE;
          end
        end
      end
      CMD_READ: begin
        r.ev    = EV_WALLS;
        r.walls = wall_bits[{ry, rx}];
      end
      default: ;
    endcase
    if (cmd == CMD_READ) begin
      r.x = rx;
      r.y = ry;
    end else begin
      r.x = walker_col;
      r.y = walker_row;
    end
    return r;
  endfunction

  // Offers one command, waits for its transfer, then records what it should return.
  task automatic send_item(input logic [1:0] cmd, input logic [1:0] dir,
                           input logic [2:0] rx, input logic [2:0] ry,
                           input logic typed, input maze_result_t want);
    maze_result_t guess;
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {ry, rx, dir};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    guess = predict_item(cmd, dir, rx, ry);
    pending_results.push_back(typed ? want : guess);
    items_sent++;
    // Idling pattern moves on by thirds of the run.
    if (items_sent * 3 < TOTAL_ITEMS) begin
      snd_idle_pct = 24;
      rcv_idle_pct = 73;
    end else if (items_sent * 3 < 2 * TOTAL_ITEMS) begin
      snd_idle_pct = 73;
      rcv_idle_pct = 24;
    end else begin
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
    end
  endtask

  task automatic send_random_step();
    logic [3:0] ways;
    logic [1:0] dir;
    ways = open_mask();
    dir  = 2'($urandom_range(3));
    // Mostly head for an open neighbour so that mazes get carved to the end.
    if (ways != 4'd0 && !maze_done && $urandom_range(99) < 70) begin
      while (!ways[dir]) dir = 2'($urandom_range(3));
    end
    send_item(CMD_STEP, dir, 3'($urandom_range(7)), 3'($urandom_range(7)), 1'b0, NO_RESULT);
  endtask

  task automatic send_random_read();
    send_item(CMD_READ, 2'($urandom_range(3)), 3'($urandom_range(7)), 3'($urandom_range(7)),
              1'b0, NO_RESULT);
  endtask

  // Compares one result transfer with the oldest expectation.
  task automatic check_result(input logic [2:0] ev, input logic [15:0] data);
    maze_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result with nothing expected: event %0d data %h", $time, ev, data);
      errors++;
    end else begin
      want = pending_results.pop_front();
      event_tally[want.ev]++;
      if (ev !== want.ev) begin
        $display("%0t: event_res expected %0d actual %0d", $time, want.ev, ev);
        errors++;
      end
      if (data[2:0] !== want.x) begin
        $display("%0t: cell_x expected %0d actual %0d", $time, want.x, data[2:0]);
        errors++;
      end
      if (data[5:3] !== want.y) begin
        $display("%0t: cell_y expected %0d actual %0d", $time, want.y, data[5:3]);
        errors++;
      end
      if (data[7:6] !== want.od) begin
        $display("%0t: opened_dir expected %0d actual %0d", $time, want.od, data[7:6]);
        errors++;
      end
      if (data[11:8] !== want.walls) begin
        $display("%0t: walls expected %h actual %h", $time, want.walls, data[11:8]);
        errors++;
      end
    end
  endtask

  // Result side: check each transfer, then choose the ready for the next edge.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) check_result(m_axis_tuser, m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Stimulus: reset, directed table, then random mazes.
  initial begin
    errors          = 0;
    items_sent      = 0;
    mazes_completed = 0;
    snd_idle_pct    = 24;
    rcv_idle_pct    = 73;
    for (int e = 0; e < 5; e++) event_tally[e] = 0;
    clear_maze();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_item(DIRECTED[i].cmd, DIRECTED[i].dir, DIRECTED[i].rx, DIRECTED[i].ry,
                DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Each pass starts a maze and walks it to completion, with reads and noise mixed in.
    while (items_sent < TOTAL_ITEMS) begin
      send_item(CMD_START, 2'($urandom_range(3)), 3'($urandom_range(7)),
                3'($urandom_range(7)), 1'b0, NO_RESULT);
      while (!maze_done && items_sent < TOTAL_ITEMS) begin
        if ($urandom_range(99) < 6) begin
          send_random_read();
        end else if ($urandom_range(99) < 2) begin
          send_item(CMD_UNKNOWN, 2'($urandom_range(3)), 3'($urandom_range(7)),
                    3'($urandom_range(7)), 1'b0, NO_RESULT);
        end else if ($urandom_range(999) < 3) begin
          // Abandon the maze part way through.
          send_item(CMD_START, 2'($urandom_range(3)), 3'($urandom_range(7)),
                    3'($urandom_range(7)), 1'b0, NO_RESULT);
        end else begin
          send_random_step();
        end
      end
      // Steps after the finish must change nothing; reads show the finished maze.
      repeat ($urandom_range(3, 1)) send_random_step();
      repeat ($urandom_range(4, 1)) send_random_read();
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d commands; %0d mazes carved to completion.", items_sent, mazes_completed);
    $display("Results: %0d idle, %0d carved, %0d backtracked, %0d finished, %0d wall reads.",
             event_tally[EV_IDLE], event_tally[EV_CARVED], event_tally[EV_BACKTRACK],
             event_tally[EV_FINISHED], event_tally[EV_WALLS]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(10_000_000);
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
